// ===== hdl/box_counting_multiscale_assert.svh =====
// Assertion macros shared by the checker of the box counting block.
`ifndef BOX_COUNTING_MULTISCALE_ASSERT_SVH
`define BOX_COUNTING_MULTISCALE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define BCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box counting check failed");

// Check a consequent in the cycle after its antecedent.
`define BCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box counting check failed");

`endif

// ===== hdl/bcm_pkg.sv =====
package bcm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int NUM_SCALES = 5;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int CFG_SIZE_W  = 11;
  localparam int PIXEL_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int SCALE_W     = 3;
  localparam int COUNT_W     = 21;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH     = 11'd1024;
  localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_HEIGHT    = 11'd1024;
  localparam logic [PIXEL_W-1:0]    RST_BLACK_THRESHOLD = 16'd45874;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLACK_THRESHOLD = 2'd2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int IDX_W = (NUM_SCALES > 1) ? $clog2(NUM_SCALES) : 1;

  // One classified pixel on its way to the mark update.
  typedef struct packed {
    logic [COL_W-1:0]      col;
    logic                  black;
    logic [NUM_SCALES-1:0] done;
    logic                  frame_end;
  } op_t;

  // Per-scale totals handed over at the end of a frame.
  typedef struct packed {
    logic                                valid;
    logic [NUM_SCALES-1:0][COUNT_W-1:0] counts;
  } snap_t;

  function automatic logic [COL_W-1:0] last_col_index(logic [CFG_SIZE_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_WIDTH) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(v - CFG_SIZE_W'(1));
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] last_row_index(logic [CFG_SIZE_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_HEIGHT) begin
      r = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      r = ROW_W'(v - CFG_SIZE_W'(1));
    end
    return r;
  endfunction

endpackage

// ===== hdl/bcm_front.sv =====
module bcm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bcm_pkg::PIXEL_W-1:0]          pixel_value,
  input  logic                                 cfg_write,
  input  logic [bcm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 q_full,
  input  logic                                 clearing,
  output logic                                 push,
  output bcm_pkg::op_t                         op
);

  logic [bcm_pkg::CFG_SIZE_W-1:0] image_width;
  logic [bcm_pkg::CFG_SIZE_W-1:0] image_height;
  logic [bcm_pkg::PIXEL_W-1:0]    black_threshold;
  logic [bcm_pkg::COL_W-1:0]      col;
  logic [bcm_pkg::ROW_W-1:0]      row;
  logic [bcm_pkg::COL_W-1:0]      col_last;
  logic [bcm_pkg::ROW_W-1:0]      row_last;
  logic                           last_col;
  logic                           last_row;
  logic                           accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= bcm_pkg::RST_IMAGE_WIDTH;
      image_height    <= bcm_pkg::RST_IMAGE_HEIGHT;
      black_threshold <= bcm_pkg::RST_BLACK_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcm_pkg::CFG_IMAGE_WIDTH:     image_width     <= cfg_data[bcm_pkg::CFG_SIZE_W-1:0];
        bcm_pkg::CFG_IMAGE_HEIGHT:    image_height    <= cfg_data[bcm_pkg::CFG_SIZE_W-1:0];
        bcm_pkg::CFG_BLACK_THRESHOLD: black_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full && !clearing;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  assign col_last = bcm_pkg::last_col_index(image_width);
  assign row_last = bcm_pkg::last_row_index(image_height);
  assign last_col = col >= col_last;
  assign last_row = row >= row_last;

  // Classify the pixel: black or not, and which boxes it closes.
  always_comb begin
    logic [bcm_pkg::COL_W-1:0] cmask;
    logic [bcm_pkg::ROW_W-1:0] rmask;
    op.col       = col;
    op.black     = pixel_value <= black_threshold;
    op.frame_end = last_col && last_row;
    for (int j = 0; j < bcm_pkg::NUM_SCALES; j++) begin
      cmask = bcm_pkg::COL_W'((32'd1 << j) - 32'd1);
      rmask = bcm_pkg::ROW_W'((32'd1 << j) - 32'd1);
      op.done[j] = (((col & cmask) == cmask) || last_col) &&
                   (((row & rmask) == rmask) || last_row);
    end
  end

  // Advance the raster position, wrapping at the last column and row.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (!last_col) begin
        col <= col + bcm_pkg::COL_W'(1);
      end else begin
        col <= '0;
        row <= last_row ? '0 : row + bcm_pkg::ROW_W'(1);
      end
    end
  end

endmodule

// ===== hdl/bcm_queue.sv =====
module bcm_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  bcm_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output bcm_pkg::op_t head_op
);

  bcm_pkg::op_t                slots [bcm_pkg::Q_DEPTH];
  logic [bcm_pkg::Q_AW-1:0]    rd_ptr;
  logic [bcm_pkg::Q_AW-1:0]    wr_ptr;
  logic [bcm_pkg::Q_AW:0]      count;

  assign full       = count == (bcm_pkg::Q_AW + 1)'(bcm_pkg::Q_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bcm_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bcm_pkg::Q_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (bcm_pkg::Q_AW + 1)'(1);
        2'b01:   count <= count - (bcm_pkg::Q_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/bcm_back.sv =====
module bcm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  bcm_pkg::op_t  head_op,
  output logic          pop,
  output logic          clearing,
  input  logic          emit_busy,
  output bcm_pkg::snap_t snap
);

  logic [bcm_pkg::COL_W-1:0]   clr_cnt;
  logic                        b_valid;
  bcm_pkg::op_t                b_op;
  logic [bcm_pkg::COUNT_W-1:0] count [bcm_pkg::NUM_SCALES];

  // Sweep every mark entry to zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + bcm_pkg::COL_W'(1);
      if (clr_cnt == bcm_pkg::COL_W'(bcm_pkg::MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Hold a frame end while the previous frame's results are still pending.
  assign pop = head_valid && !clearing &&
               !(head_op.frame_end && ((b_valid && b_op.frame_end) || emit_busy));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op <= head_op;
    end
  end

  assign snap.valid = b_valid && b_op.frame_end;

  for (genvar j = 0; j < bcm_pkg::NUM_SCALES; j++) begin : g_scale
    localparam int DEPTH = ((bcm_pkg::MAX_WIDTH - 1) >> j) + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        marks [DEPTH];
    logic                        rdata;
    logic [AW-1:0]               raddr;
    logic [AW-1:0]               baddr;
    logic [AW-1:0]               caddr;
    logic                        wr_valid;
    logic [AW-1:0]               wr_addr;
    logic                        wr_data;
    logic                        mark_rd;
    logic                        mark_new;
    logic                        wdata;
    logic                        inc;
    logic [bcm_pkg::COUNT_W-1:0] count_next;

    assign raddr = AW'(head_op.col >> j);
    assign baddr = AW'(b_op.col >> j);
    assign caddr = AW'(clr_cnt >> j);

    // Bypass the write of the cycle before, which the registered read missed.
    assign mark_rd  = (wr_valid && (wr_addr == baddr)) ? wr_data : rdata;
    assign mark_new = mark_rd | b_op.black;
    assign wdata    = b_op.done[j] ? 1'b0 : mark_new;

    always_ff @(posedge clk) begin
      rdata <= marks[raddr];
      if (clearing) begin
        marks[caddr] <= 1'b0;
      end else if (b_valid) begin
        marks[baddr] <= wdata;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        wr_valid <= 1'b0;
      end else begin
        wr_valid <= b_valid;
      end
    end

    always_ff @(posedge clk) begin
      wr_addr <= baddr;
      wr_data <= wdata;
    end

    assign inc        = b_valid && b_op.done[j] && mark_new;
    assign count_next = (inc && (count[j] != bcm_pkg::COUNT_MAX)) ?
                        count[j] + bcm_pkg::COUNT_W'(1) : count[j];
    assign snap.counts[j] = count_next;

    always_ff @(posedge clk) begin
      if (rst) begin
        count[j] <= '0;
      end else if (snap.valid) begin
        count[j] <= '0;
      end else begin
        count[j] <= count_next;
      end
    end
  end

endmodule

// ===== hdl/bcm_emit.sv =====
module bcm_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  bcm_pkg::snap_t                 snap,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bcm_pkg::SCALE_W-1:0]    scale_index,
  output logic [bcm_pkg::COUNT_W-1:0]    box_count,
  output logic                           last
);

  logic                                        valid;
  logic [bcm_pkg::IDX_W-1:0]                   idx;
  logic [bcm_pkg::NUM_SCALES-1:0][bcm_pkg::COUNT_W-1:0] counts;
  logic                                        at_last;

  assign at_last = idx == bcm_pkg::IDX_W'(bcm_pkg::NUM_SCALES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (snap.valid) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && out_ready) begin
      if (at_last) begin
        valid <= 1'b0;
      end
      idx <= idx + bcm_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (snap.valid) begin
      counts <= snap.counts;
    end
  end

  assign busy        = valid;
  assign out_valid   = valid;
  assign scale_index = bcm_pkg::SCALE_W'(idx);
  assign box_count   = counts[idx];
  assign last        = at_last;

endmodule

// ===== hdl/box_counting_multiscale.sv =====
// Throughput: one pixel per cycle unless the queue is full or the marks are being
//   cleared; a frame end waits at the queue head while the previous frame's five
//   results are still being delivered. Results: the back end pops the frame end,
//   and the result stage registers the totals and raises out_valid; one result per
//   cycle while out_ready is high. Reset: synchronous; registers take their reset
//   values; a sweep clears the column marks, one per cycle, with in_ready held low.
module box_counting_multiscale (
  input  logic                                 clk,
  input  logic                                 rst,
  // Pixel channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bcm_pkg::PIXEL_W-1:0]          pixel_value,
  // Configuration writes
  input  logic                                 cfg_write,
  input  logic [bcm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bcm_pkg::SCALE_W-1:0]          scale_index,
  output logic [bcm_pkg::COUNT_W-1:0]          box_count,
  output logic                                 last
);

  // Front: holds the configuration and the raster position, marks each pixel
  // black or not and works out which boxes it closes at every scale.
  logic           push;
  bcm_pkg::op_t   push_op;
  logic           q_full;
  logic           clearing;

  // Queue head as seen by the back end.
  logic           pop;
  logic           head_valid;
  bcm_pkg::op_t   head_op;

  // Frame totals passed from the back end to the result stage.
  bcm_pkg::snap_t snap;
  logic           emit_busy;

  bcm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .clearing    (clearing),
    .push        (push),
    .op          (push_op)
  );

  // Short queue: lets the front keep taking pixels while the back end holds a
  // frame end; in_ready drops once all four slots are taken or while clearing.
  bcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // Back end: one mark memory per scale, indexed by box column. Read on issue,
  // update in the next cycle with a bypass for back-to-back hits on the same box.
  // A closed box counts if marked and drops its mark. The frame end snapshots
  // the counters and clears them in the same cycle.
  bcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .clearing   (clearing),
    .emit_busy  (emit_busy),
    .snap       (snap)
  );

  // Result stage: registered totals, delivered one scale per transaction,
  // rising order, last on the highest scale.
  bcm_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .snap        (snap),
    .busy        (emit_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scale_index (scale_index),
    .box_count   (box_count),
    .last        (last)
  );

endmodule

// ===== hdl/bcm_checker.sv =====
`include "box_counting_multiscale_assert.svh"

module bcm_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [bcm_pkg::SCALE_W-1:0]          scale_index,
  input logic [bcm_pkg::COUNT_W-1:0]          box_count,
  input logic                                 last
);

  // A stalled result holds.
  `BCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(scale_index) && $stable(box_count) && $stable(last))

  // The mark sweep after reset keeps the pixel channel closed.
  `BCM_ASSERT_NOW(a_clear_blocks_input, $past(rst), !in_ready)

  // The final result of a frame carries the highest scale.
  `BCM_ASSERT_NOW(a_last_scale, out_valid && last, scale_index == 3'(bcm_pkg::NUM_SCALES - 1))

  // Results of one frame follow without a gap, scale by scale.
  `BCM_ASSERT_NEXT(a_scale_step, out_valid && out_ready && !last, out_valid && (scale_index == $past(scale_index) + 3'd1))

  // Nothing follows the last result until a new frame ends.
  `BCM_ASSERT_NEXT(a_run_ends, out_valid && out_ready && last, !out_valid)

endmodule

bind box_counting_multiscale bcm_checker u_checker (.*);
